// ===== rtl/core/m3i_pkg.sv =====
// Shared types, widths, cofactor index tables and the output clip function.
`default_nettype none
package m3i_pkg;

  localparam int unsigned NUM_EL    = 9;
  localparam int unsigned EL_W      = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned COF_W     = 65;
  localparam int unsigned DET_W     = 98;
  localparam int unsigned DMAG_W    = 96;
  localparam int unsigned CMAG_W    = 64;
  localparam int unsigned Q_W       = 32;
  localparam int unsigned DIV_STEPS = 32;

  // cofactor k = a[X]*a[W] - a[Y]*a[Z], negated where COF_NEG is set
  localparam int unsigned COF_X[NUM_EL] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
  localparam int unsigned COF_W_[NUM_EL] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
  localparam int unsigned COF_Y[NUM_EL] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
  localparam int unsigned COF_Z[NUM_EL] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};
  localparam logic [NUM_EL-1:0] COF_NEG = 9'b010101010;

  typedef logic signed [EL_W-1:0]  el_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           ovf;
    logic           neg;
  } lane_res_t;

  // Clip a sign-magnitude value to Q16.16; returns {sat, value}.
  function automatic logic [Q_W:0] clip32(input logic neg, input logic ovf,
                                          input logic [Q_W-1:0] m);
    logic [Q_W:0] r;
    if (!neg) begin
      if (ovf || m > 32'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, m};
    end else begin
      if (ovf || m > 32'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(~m + 32'd1)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/matrix3x3_inverse.sv =====
// Top level: 3x3 Q16.16 matrix inverse by adjugate, nine divider lanes.
//
// One matrix beat enters per clock while the skid stage is empty and one result beat
// leaves per clock while m_tready is high, through the pipeline and the output register.
// Stages: 18 products, cofactors, split determinant products, terms, determinant
// sum, sign/magnitude, divider overflow check, 32 restoring quotient stages (one
// bit each, nine lanes side by side), then a merge stage that clips every lane,
// clips the determinant, ORs the saturation flags and zeroes a singular result.
// An output register with a skid stage decouples the two sides; the pipeline
// holds only while the skid stage is full. Quotients and the determinant truncate
// toward zero. s_tdata: a00,a01,a02,a10,a11,a12,a20,a21,a22 from bit 0 up.
// m_tdata: inv00..inv22 then det_value; m_tuser: singular, saturated.
`default_nettype none
module matrix3x3_inverse (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [287:0] s_tdata,  // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [319:0]      m_tdata,  // inv00..inv22, det_value
  output logic [1:0]        m_tuser   // singular, saturated
);
  import m3i_pkg::*;

  localparam int unsigned LAT = 7 + DIV_STEPS + 1;

  logic           en;
  logic [LAT-1:0] vld;
  el_t  [NUM_EL-1:0] a;
  cof_t [NUM_EL-1:0] cof2;
  el_t  [2:0]        row0;
  det_t              det5;
  cof_t [NUM_EL-1:0] cof3, cof4, cof5;

  // stage 6: sign and magnitude
  logic [CMAG_W-1:0] cmag [NUM_EL];
  logic              cneg [NUM_EL];
  logic [DMAG_W-1:0] dmag6;
  logic              dneg6;
  logic              dzero6;

  // determinant side line through the divider stages
  logic [CMAG_W-1:0] dhi  [DIV_STEPS+1];
  logic              dng  [DIV_STEPS+1];
  logic              dzr  [DIV_STEPS+1];

  lane_res_t         lres [NUM_EL];
  logic [319:0]      p_data;
  logic [1:0]        p_user;
  logic [319:0]      skid_data;
  logic [1:0]        skid_user;
  logic              skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  for (genvar i = 0; i < NUM_EL; i++) begin : g_in
    assign a[i] = s_tdata[EL_W*i +: EL_W];
  end

  m3i_cof u_cof (.clk, .en, .a, .cof(cof2), .row0);

  m3i_det u_det (.clk, .en, .row0, .cof(cof2[2:0]), .det(det5));

  // hold cofactors alongside the determinant stages
  always_ff @(posedge clk) begin
    if (en) begin
      cof3 <= cof2;
      cof4 <= cof3;
      cof5 <= cof4;
    end
  end

  for (genvar i = 0; i < NUM_EL; i++) begin : g_mag
    // lane i takes the transposed cofactor
    localparam int unsigned SRC = (i % 3) * 3 + i / 3;
    logic signed [COF_W-1:0] c;
    assign c = cof5[SRC];
    always_ff @(posedge clk) begin
      if (en) begin
        cneg[i] <= c[COF_W-1];
        cmag[i] <= c[COF_W-1] ? CMAG_W'(-c) : c[CMAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg6  <= det5[DET_W-1];
      dmag6  <= det5[DET_W-1] ? DMAG_W'(-det5) : det5[DMAG_W-1:0];
      dzero6 <= (det5 == '0);
    end
  end

  for (genvar i = 0; i < NUM_EL; i++) begin : g_lane
    m3i_div u_div (
      .clk, .en,
      .mag (cmag[i]),
      .dmag(dmag6),
      .neg (cneg[i] ^ dneg6),
      .res (lres[i])
    );
  end

  // advance the determinant alongside the divider overflow check stage
  always_ff @(posedge clk) begin
    if (en) begin
      dhi[0] <= dmag6[DMAG_W-1:32];
      dng[0] <= dneg6;
      dzr[0] <= dzero6;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_dline
    always_ff @(posedge clk) begin
      if (en) begin
        dhi[s+1] <= dhi[s];
        dng[s+1] <= dng[s];
        dzr[s+1] <= dzr[s];
      end
    end
  end

  // merge: clip lanes and determinant, combine flags
  always_ff @(posedge clk) begin
    logic [Q_W:0] cl;
    logic         sat;
    if (en) begin
      sat = 1'b0;
      for (int i = 0; i < NUM_EL; i++) begin
        cl = clip32(lres[i].neg, lres[i].ovf, lres[i].q);
        sat = sat | cl[Q_W];
        p_data[EL_W*i +: EL_W] <= dzr[DIV_STEPS] ? '0 : cl[Q_W-1:0];
      end
      cl = clip32(dng[DIV_STEPS], |dhi[DIV_STEPS][CMAG_W-1:32],
                  dhi[DIV_STEPS][31:0]);
      sat = sat | cl[Q_W];
      p_data[319:288] <= dzr[DIV_STEPS] ? '0 : cl[Q_W-1:0];
      p_user <= {sat & !dzr[DIV_STEPS], dzr[DIV_STEPS]};
    end
  end

  // valid line and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (en) vld <= {vld[LAT-2:0], s_tvalid};
      if (skid_valid) begin
        if (m_tready) skid_valid <= 1'b0;
      end else if (vld[LAT-1]) begin
        if (!m_tvalid || m_tready) m_tvalid <= 1'b1;
        else skid_valid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end
    end else if (vld[LAT-1]) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= p_data;
        m_tuser <= p_user;
      end else begin
        skid_data <= p_data;
        skid_user <= p_user;
      end
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid full with empty output");
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
    else $error("singular result not zeroed");
  a_hold_line: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld)) else $error("pipeline moved while held");

endmodule
`default_nettype wire

// ===== rtl/core/m3i_cof.sv =====
// Eighteen element products and the nine signed cofactors, two stages.
`default_nettype none
module m3i_cof (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire m3i_pkg::el_t [m3i_pkg::NUM_EL-1:0]     a,
  output m3i_pkg::cof_t [m3i_pkg::NUM_EL-1:0]         cof,
  output m3i_pkg::el_t [2:0]                          row0
);
  import m3i_pkg::*;

  logic signed [PROD_W-1:0] pa [NUM_EL];
  logic signed [PROD_W-1:0] pb [NUM_EL];
  el_t                      row0_d [3];

  for (genvar k = 0; k < NUM_EL; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa[k] <= PROD_W'(a[COF_X[k]]) * PROD_W'(a[COF_W_[k]]);
        pb[k] <= PROD_W'(a[COF_Y[k]]) * PROD_W'(a[COF_Z[k]]);
        if (COF_NEG[k]) cof[k] <= COF_W'(pb[k]) - COF_W'(pa[k]);
        else cof[k] <= COF_W'(pa[k]) - COF_W'(pb[k]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        row0_d[i] <= a[i];
        row0[i]   <= row0_d[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/m3i_det.sv =====
// Determinant along row 0: split products, term assembly, three-way sum.
`default_nettype none
module m3i_det (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire m3i_pkg::el_t  [2:0]    row0,
  input  wire m3i_pkg::cof_t [2:0]    cof,
  output m3i_pkg::det_t               det
);
  import m3i_pkg::*;

  logic signed [COF_W-1:0] ph [3];
  logic signed [COF_W-1:0] pl [3];
  det_t                    term [3];

  for (genvar i = 0; i < 3; i++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) begin
        // cofactor = hi * 2^32 + lo, lo unsigned
        pl[i]   <= COF_W'(row0[i]) * COF_W'($signed({1'b0, cof[i][31:0]}));
        ph[i]   <= COF_W'(row0[i]) * COF_W'($signed(cof[i][COF_W-1:32]));
        term[i] <= $signed({ph[i][COF_W-1], ph[i], 32'b0})
                 + $signed({{(DET_W-COF_W){pl[i][COF_W-1]}}, pl[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) det <= term[0] + term[1] + term[2];
  end

endmodule
`default_nettype wire

// ===== rtl/core/m3i_div.sv =====
// One divider lane: overflow check, then one restoring quotient bit per stage.
`default_nettype none
module m3i_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [m3i_pkg::CMAG_W-1:0]    mag,
  input  wire logic [m3i_pkg::DMAG_W-1:0]    dmag,
  input  wire logic                          neg,
  output m3i_pkg::lane_res_t                 res
);
  import m3i_pkg::*;

  logic [DMAG_W-1:0] r   [DIV_STEPS+1];
  logic [DMAG_W-1:0] d   [DIV_STEPS+1];
  logic [Q_W-1:0]    q   [DIV_STEPS+1];
  logic              ovf [DIV_STEPS+1];
  logic              n   [DIV_STEPS+1];

  // quotient fits 32 bits only when mag < dmag
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= DMAG_W'(mag);
      d[0]   <= dmag;
      q[0]   <= '0;
      ovf[0] <= (DMAG_W'(mag) >= dmag);
      n[0]   <= neg;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DMAG_W:0] r2;
    logic [DMAG_W:0] diff;
    logic            ge;
    always_comb begin
      r2   = {r[s], 1'b0};
      diff = r2 - {1'b0, d[s]};
      ge   = (r2 >= {1'b0, d[s]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]   <= ge ? diff[DMAG_W-1:0] : r2[DMAG_W-1:0];
        q[s+1]   <= {q[s][Q_W-2:0], ge};
        d[s+1]   <= d[s];
        ovf[s+1] <= ovf[s];
        n[s+1]   <= n[s];
      end
    end
  end

  assign res = '{q: q[DIV_STEPS], ovf: ovf[DIV_STEPS], neg: n[DIV_STEPS]};

endmodule
`default_nettype wire
